/* hw/rtl/lpcd_pkg.sv */
// ----------------------------------------------------------------------------
// lpcd_pkg
// Types, constants and codes shared by the page cache directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpcd_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int PAGE_BYTES     = 256;
	localparam int ADDR_BITS      = 23;

	localparam int ADDRESS_W   = 23;
	localparam int PAGE_W      = 15;
	localparam int OFFSET_W    = 8;
	localparam int SLOT_W      = 3;
	localparam int OFFSET_BITS = $clog2(PAGE_BYTES);

	localparam logic [ADDRESS_W-1:0] ADDR_MASK =
		ADDRESS_W'((64'd1 << ADDR_BITS) - 64'd1);

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [ADDRESS_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic                fill_needed;
		logic [PAGE_W-1:0]   page_number;
		logic [OFFSET_W-1:0] byte_offset;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} dp_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} ctrl_state_t;

endpackage

/* hw/rtl/lpcd_stream_if.sv */
// ----------------------------------------------------------------------------
// lpcd_stream_if
// Valid/ready channel that moves one payload beat per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpcd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/lpcd_ctrl.sv */
// ----------------------------------------------------------------------------
// lpcd_ctrl
// Sequencer: accept, tag lookup, recency update and result beat hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lpcd_pkg::dp_cmd_t cmd
);
	import lpcd_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        rsp_valid_q;
	logic        commit;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		commit     = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp_ready);
		req_ready  = (state_q == ST_IDLE) || commit;
		accept     = req_valid && req_ready;
		cmd.load   = accept;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.commit = commit;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (commit) begin
					state_d = accept ? ST_LOOKUP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* hw/rtl/lpcd_dpath.sv */
// ----------------------------------------------------------------------------
// lpcd_dpath
// Tag store, parallel tag compare, age-rank recency order and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpcd_dpath #(
	parameter int SLOT_COUNT = lpcd_pkg::SLOT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpcd_pkg::dp_cmd_t cmd,
	input  lpcd_pkg::req_t    req_data,
	output lpcd_pkg::rsp_t    rsp_data
);
	import lpcd_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	logic                 mode_q;
	logic [PAGE_W-1:0]    page_q;
	logic [OFFSET_W-1:0]  offset_q;
	logic [PAGE_W-1:0]    tag_q [SLOT_COUNT];
	logic [IDX_W-1:0]     age_q [SLOT_COUNT];
	logic [CNT_W-1:0]     used_q;
	logic [SLOT_COUNT-1:0] match_q;
	logic [SLOT_COUNT-1:0] oldest_q;
	rsp_t                 rsp_q;

	logic [ADDRESS_W-1:0] addr_m;
	logic                 hit;
	logic                 full;
	logic                 fill;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     victim_idx;
	logic [IDX_W-1:0]     hit_age;
	logic [IDX_W-1:0]     where;
	logic [CNT_W-1:0]     thr;

	assign addr_m = req_data.address & ADDR_MASK;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= req_data.mode;
			page_q   <= PAGE_W'(addr_m >> OFFSET_BITS);
			offset_q <= OFFSET_W'(addr_m[OFFSET_BITS-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				match_q[i]  <= (CNT_W'(i) < used_q) && (tag_q[i] == page_q);
				oldest_q[i] <= (age_q[i] == IDX_W'(SLOT_COUNT - 1));
			end
		end
	end

	always_comb begin
		hit        = |match_q;
		full       = (used_q == CNT_W'(SLOT_COUNT));
		fill       = (mode_q == MODE_READ) && !hit;
		hit_idx    = '0;
		victim_idx = '0;
		hit_age    = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (match_q[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
				hit_age = hit_age | age_q[i];
			end
			if (oldest_q[i]) begin
				victim_idx = victim_idx | IDX_W'(i);
			end
		end
		if (hit) begin
			where = hit_idx;
			thr   = CNT_W'(hit_age);
		end else if (fill && full) begin
			where = victim_idx;
			thr   = CNT_W'(SLOT_COUNT - 1);
		end else if (fill) begin
			where = used_q[IDX_W-1:0];
			thr   = used_q;
		end else begin
			where = '0;
			thr   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.commit && fill && !full) begin
			used_q <= used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (mode_q == MODE_READ)) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (IDX_W'(i) == where) begin
					age_q[i] <= '0;
				end else if ((CNT_W'(i) < used_q) && (CNT_W'(age_q[i]) < thr)) begin
					age_q[i] <= age_q[i] + IDX_W'(1);
				end
			end
			if (fill) begin
				tag_q[where] <= page_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.hit         <= hit;
			rsp_q.slot        <= SLOT_W'(where);
			rsp_q.fill_needed <= fill;
			rsp_q.page_number <= page_q;
			rsp_q.byte_offset <= offset_q;
		end
	end

	assign rsp_data = rsp_q;

endmodule

/* hw/rtl/lru_page_cache_directory.sv */
// ----------------------------------------------------------------------------
// lru_page_cache_directory
// Fully associative page directory with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request beat (mode, address) yields exactly one response beat. A read
// hit makes the page most recently used; a read miss takes the next free slot,
// or the least recently used slot once all are filled, and raises fill_needed.
// A write only reports hit and slot and leaves the directory unchanged; on a
// write miss the slot field is 0. An item passes a lookup state, with the
// parallel compare of all tags, and an update state, with the recency
// update and the response register. A new request is taken in the update
// state, so a new item can be taken before the last one is through while
// the response side keeps up; a held response beat stalls the update state.
`timescale 1ns / 1ps

module lru_page_cache_directory #(
	parameter int SLOT_COUNT = lpcd_pkg::SLOT_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lpcd_stream_if.sink          req,
	lpcd_stream_if.source        rsp
);
	import lpcd_pkg::*;

	dp_cmd_t cmd;
	rsp_t    rsp_data;
	req_t    req_data;

	assign req_data = req.data;

	lpcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	lpcd_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

	assign rsp.data = rsp_data;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("response beat missing after update");

	a_gap_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken during lookup cycle");

	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.data.hit && rsp.data.fill_needed))
		else $error("hit and fill both set");

	a_write_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.hit && !rsp.data.fill_needed) |-> (rsp.data.slot == '0))
		else $error("nonzero slot on write miss");

endmodule

/* tb/lru_page_cache_directory_tb.sv */
// ----------------------------------------------------------------------------
// lru_page_cache_directory_tb
// Self-checking bench for the LRU page cache directory.
// ----------------------------------------------------------------------------
// A clocked driver sends access beats from a queue that the stimulus process
// fills. A clocked monitor runs each accepted access through a behavioral
// directory with its own tags and recency list. It then checks every response
// beat, field by field, against the oldest prediction.
// The run has a directed part: fills, hits on the newest, oldest and middle
// pages, write hits and misses, replacement and the address extremes. After it
// come random phases over small page pools with sender gaps and receiver
// stalls, a long receiver hold-off and full drains between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_cache_directory_tb;
	import lpcd_pkg::*;

	localparam int SLOTS       = SLOT_COUNT_DEF;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpcd_stream_if #(.payload_t(req_t)) req_bus ();
	lpcd_stream_if #(.payload_t(rsp_t)) rsp_bus ();

	lru_page_cache_directory dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	req_t access_queue[$];
	rsp_t predicted_rsp[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_go = 1'b0;
	logic rsp_hold = 1'b0;
	int mismatch_count = 0;

	int read_hits = 0;
	int fills = 0;
	int replacements = 0;
	int write_hits = 0;
	int write_misses = 0;
	int accesses = 0;

	logic [PAGE_W-1:0] tag_of [SLOTS];
	logic [SLOT_W-1:0] older_of [SLOTS];
	logic [SLOT_W-1:0] newer_of [SLOTS];
	logic [SLOT_W-1:0] mru_slot = '0;
	logic [SLOT_W-1:0] lru_slot = '0;
	int slots_filled = 0;

	logic [PAGE_W-1:0] page_pool [16];

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		req_bus.valid = 1'b0;
		req_bus.data = '0;
		rsp_bus.ready = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic void move_to_front(logic [SLOT_W-1:0] s);
		older_of[s] = mru_slot;
		newer_of[mru_slot] = s;
		newer_of[s] = s;
		mru_slot = s;
	endfunction

	function automatic rsp_t access_directory(req_t acc);
		logic [ADDRESS_W-1:0] a;
		logic [PAGE_W-1:0] pg;
		logic [SLOT_W-1:0] where;
		logic [SLOT_W-1:0] nw;
		bit found;
		bit fill;
		rsp_t r;
		a = acc.address & ADDR_MASK;
		pg = PAGE_W'(a >> OFFSET_BITS);
		found = 1'b0;
		fill = 1'b0;
		where = '0;
		for (int i = 0; i < slots_filled; i++) begin
			if (!found && tag_of[i] == pg) begin
				found = 1'b1;
				where = SLOT_W'(i);
			end
		end
		if (acc.mode == MODE_READ) begin
			if (found) begin
				read_hits++;
				if (where != mru_slot) begin
					nw = newer_of[where];
					if (where == lru_slot) begin
						older_of[nw] = nw;
						lru_slot = nw;
					end else begin
						older_of[nw] = older_of[where];
						newer_of[older_of[where]] = nw;
					end
					move_to_front(where);
				end
			end else begin
				fill = 1'b1;
				fills++;
				if (slots_filled < SLOTS) begin
					where = SLOT_W'(slots_filled);
					tag_of[where] = pg;
					if (slots_filled == 0) begin
						older_of[where] = where;
						newer_of[where] = where;
						mru_slot = where;
						lru_slot = where;
					end else begin
						move_to_front(where);
					end
					slots_filled++;
				end else begin
					replacements++;
					where = lru_slot;
					nw = newer_of[where];
					older_of[nw] = nw;
					lru_slot = nw;
					tag_of[where] = pg;
					move_to_front(where);
				end
			end
		end else if (found) begin
			write_hits++;
		end else begin
			write_misses++;
		end
		r.hit = found;
		r.slot = (found || fill) ? where : '0;
		r.fill_needed = fill;
		r.page_number = pg;
		r.byte_offset = a[OFFSET_W-1:0];
		return r;
	endfunction

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// driver: advance only when the current beat is taken or none is offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.data <= '0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (access_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_bus.valid <= 1'b1;
				req_bus.data <= access_queue.pop_front();
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_bus.ready <= 1'b0;
		else
			rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
	end

	// long receiver hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				rsp_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (predicted_rsp.size() == 0) begin
					$display("%0t: response beat with nothing expected, got %h", $time,
						rsp_bus.data);
					mismatch_count++;
				end else begin
					want = predicted_rsp.pop_front();
					check_field("hit", want.hit, rsp_bus.data.hit);
					check_field("slot", want.slot, rsp_bus.data.slot);
					check_field("fill_needed", want.fill_needed, rsp_bus.data.fill_needed);
					check_field("page_number", want.page_number, rsp_bus.data.page_number);
					check_field("byte_offset", want.byte_offset, rsp_bus.data.byte_offset);
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				accesses++;
				predicted_rsp.push_back(access_directory(req_bus.data));
			end
		end
	end

	task automatic queue_access(logic mode, int page, int offset);
		req_t acc;
		acc.mode = mode;
		acc.address = {PAGE_W'(page), OFFSET_W'(offset)};
		access_queue.push_back(acc);
	endtask

	task automatic drain();
		while (access_queue.size() != 0 || predicted_rsp.size() != 0 || req_bus.valid)
			@(negedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall, int count, int pool_n, bit hold);
		req_t acc;
		@(negedge clk);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		for (int i = 0; i < pool_n; i++)
			page_pool[i] = PAGE_W'($urandom);
		if (hold)
			hold_go = 1'b1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 80) begin
				acc.mode = ($urandom_range(3) == 0) ? MODE_WRITE : MODE_READ;
				acc.address = {page_pool[$urandom_range(pool_n - 1)], OFFSET_W'($urandom)};
			end else begin
				acc.mode = $urandom_range(1) ? MODE_WRITE : MODE_READ;
				acc.address = ADDRESS_W'($urandom);
			end
			access_queue.push_back(acc);
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// write miss on an empty directory, then fill every slot
		queue_access(MODE_WRITE, 0, 0);
		queue_access(MODE_READ, 0, 0);
		for (int p = 1; p < 7; p++)
			queue_access(MODE_READ, p * 1000, p * 37);
		queue_access(MODE_READ, 32767, 255);
		queue_access(MODE_READ, 32767, 0);
		queue_access(MODE_READ, 0, 128);
		queue_access(MODE_READ, 3000, 1);
		queue_access(MODE_WRITE, 5000, 255);
		queue_access(MODE_WRITE, 20000, 7);
		queue_access(MODE_READ, 20000, 9);
		queue_access(MODE_READ, 1000, 2);
		queue_access(MODE_READ, 2000, 3);
		queue_access(MODE_WRITE, 32767, 255);
		queue_access(MODE_READ, 0, 0);
		queue_access(MODE_WRITE, 16383, 170);
		queue_access(MODE_READ, 21845, 85);
		drain();

		run_phase(0, 0, 300, 12, 1'b0);
		run_phase(65, 0, 300, 10, 1'b0);
		run_phase(0, 65, 300, 14, 1'b0);
		run_phase(21, 21, 400, 9, 1'b0);
		run_phase(0, 0, 150, 12, 1'b1);
		run_phase(0, 0, 300, 6, 1'b0);

		repeat (10) @(negedge clk);
		$display("Checked %0d accesses: %0d read hits, %0d fills (%0d replacements),",
			accesses, read_hits, fills, replacements);
		$display("%0d write hits, %0d write misses; gaps, stalls and a long hold-off applied",
			write_hits, write_misses);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
